/* design/cpr_pkg.sv */
package cpr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int SLOT_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int FAULT_W    = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [FAULT_W-1:0]   t_fault_cnt;

    typedef enum logic {
        ST_IDLE,
        ST_MATCH
    } t_state;

    // lookup context, broadcast to every cell
    typedef struct packed {
        t_page page;
        t_cnt  active;
        t_cnt  limit;
        t_slot hand;
    } t_look;

    // update command, broadcast to every cell
    typedef struct packed {
        logic  clear_all;
        logic  hit_en;
        logic  write_en;
        logic  sweep_en;
        logic  wrap;
        t_slot slot;
    } t_upd;

    // carries passed from cell to cell
    typedef struct packed {
        logic hit_seen;
        logic hi_seen;
        logic lo_seen;
    } t_chain;

    // per-cell pick flags, one-hot across the row
    typedef struct packed {
        logic hit;
        logic hi;
        logic lo;
    } t_flag;

endpackage

/* design/cpr_if.sv */
interface cpr_in_if import cpr_pkg::*;;
    logic  valid;
    logic  ready;
    t_page page_number;
    logic  new_sequence;

    modport source (output valid, output page_number, output new_sequence, input ready);
    modport sink   (input valid, input page_number, input new_sequence, output ready);
endinterface

interface cpr_out_if import cpr_pkg::*;;
    logic       valid;
    logic       ready;
    logic       fault;
    t_slot      frame_slot;
    logic       evicted_valid;
    t_page      evicted_page;
    t_fault_cnt fault_total;

    modport source (output valid, output fault, output frame_slot, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input fault, input frame_slot, input evicted_valid,
                    input evicted_page, input fault_total, output ready);
endinterface

/* design/cpr_cell.sv */
module cpr_cell import cpr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_slot  i_idx,
    input  t_look  i_look,
    input  t_upd   i_upd,
    input  t_chain i_chain,
    output t_chain o_chain,
    output t_flag  o_flag,
    output t_page  o_page
);

    t_page r_page;
    logic  r_ref;

    logic in_range;
    logic is_active;
    logic match;
    logic clear_cand;
    logic at_or_after_hand;
    logic swept;
    logic sel;

    always_comb begin
        in_range         = CNT_W'(i_idx) < i_look.limit;
        is_active        = CNT_W'(i_idx) < i_look.active;
        match            = is_active && (r_page == i_look.page);
        clear_cand       = in_range && !r_ref;
        at_or_after_hand = i_idx >= i_look.hand;

        o_flag.hit = match && !i_chain.hit_seen;
        o_flag.hi  = clear_cand && at_or_after_hand && !i_chain.hi_seen;
        o_flag.lo  = clear_cand && !i_chain.lo_seen;

        o_chain.hit_seen = i_chain.hit_seen || match;
        o_chain.hi_seen  = i_chain.hi_seen || (clear_cand && at_or_after_hand);
        o_chain.lo_seen  = i_chain.lo_seen || clear_cand;

        // cells the hand passed over on its way to the victim
        if (i_upd.wrap) begin
            swept = in_range && (at_or_after_hand || (i_idx < i_upd.slot));
        end else begin
            swept = in_range && at_or_after_hand && (i_idx < i_upd.slot);
        end
        sel = (i_idx == i_upd.slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= 1'b0;
        end else if (i_upd.clear_all) begin
            r_ref <= 1'b0;
        end else if (i_upd.hit_en && sel) begin
            r_ref <= 1'b1;
        end else if (i_upd.write_en && sel) begin
            r_ref <= 1'b0;
        end else if (i_upd.sweep_en && swept) begin
            r_ref <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.write_en && sel) begin
            r_page <= i_look.page;
        end
    end

    assign o_page = r_page;

endmodule

/* design/clock_page_replacement_top.sv */
// Channel    Dir  Payload                                                  Transfer
// i_req      in   page_number[15:0], new_sequence                          valid & ready
// o_rsp      out  fault, frame_slot[3:0], evicted_valid, evicted_page[15:0],
//                 fault_total[31:0]                                        valid & ready
// i_cfg_*    in   frames_in_use[4:0]                                       i_cfg_we
//
// Each reference takes the transfer, then one lookup/commit in ST_MATCH in which
// the 16-cell row resolves the tag match and the rotating clear-bit search.
// The commit waits while the result register is still held by the sink; a new
// request can be taken while an earlier result sits in that register.
// Synchronous active-low reset empties all frames, hand and fault count, and sets
// frames_in_use to 4. new_sequence does the same emptying on the request's transfer.
module clock_page_replacement_top import cpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    cpr_in_if.sink           i_req,
    cpr_out_if.source        o_rsp
);

    // config and sequence state
    logic [CFG_W-1:0] r_frames;
    t_cnt             r_filled;
    t_cnt             n_filled;
    t_slot            r_hand;
    t_slot            n_hand;
    t_fault_cnt       r_faults;
    t_fault_cnt       n_faults;
    t_page            r_page;
    t_state           r_state;
    t_state           n_state;

    // result register
    logic             r_out_valid;
    logic             r_out_fault;
    t_slot            r_out_slot;
    logic             r_out_ev_valid;
    t_page            r_out_ev_page;
    t_fault_cnt       r_out_total;

    logic   in_xfer;
    logic   commit;
    t_cnt   limit;
    t_cnt   active;
    logic   full;
    t_slot  hand_eff;
    t_look  look;
    t_upd   upd;
    t_chain chain [MAX_FRAMES+1];
    t_flag  flags [MAX_FRAMES];
    t_page  pages [MAX_FRAMES];
    logic   any_hit;
    logic   any_hi;
    logic   any_lo;
    t_slot  hit_slot;
    t_slot  hi_slot;
    t_slot  lo_slot;
    t_slot  victim;
    t_slot  slot;
    t_fault_cnt fault_inc;

    // clamp frames_in_use into 1..MAX_FRAMES
    always_comb begin
        if (r_frames == '0) begin
            limit = CNT_W'(1);
        end else if (CNT_W'(r_frames) > CNT_W'(MAX_FRAMES)) begin
            limit = CNT_W'(MAX_FRAMES);
        end else begin
            limit = CNT_W'(r_frames);
        end
        active   = (r_filled < limit) ? r_filled : limit;
        full     = r_filled >= limit;
        hand_eff = (CNT_W'(r_hand) >= limit) ? '0 : r_hand;
    end

    assign look.page   = r_page;
    assign look.active = active;
    assign look.limit  = limit;
    assign look.hand   = hand_eff;

    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        cpr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_look  (look),
            .i_upd   (upd),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_flag  (flags[g]),
            .o_page  (pages[g])
        );
    end

    // flags are one-hot per kind, so OR-encoding gives the index
    always_comb begin
        hit_slot = '0;
        hi_slot  = '0;
        lo_slot  = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (flags[i].hit) hit_slot = hit_slot | SLOT_W'(i);
            if (flags[i].hi)  hi_slot  = hi_slot | SLOT_W'(i);
            if (flags[i].lo)  lo_slot  = lo_slot | SLOT_W'(i);
        end
    end

    assign any_hit = chain[MAX_FRAMES].hit_seen;
    assign any_hi  = chain[MAX_FRAMES].hi_seen;
    assign any_lo  = chain[MAX_FRAMES].lo_seen;

    // first clear bit at/after the hand, else first clear bit from slot 0,
    // else every bit was set: the hand clears a full lap and lands where it began
    always_comb begin
        if (any_hi) begin
            victim = hi_slot;
        end else if (any_lo) begin
            victim = lo_slot;
        end else begin
            victim = hand_eff;
        end
        if (any_hit) begin
            slot = hit_slot;
        end else if (full) begin
            slot = victim;
        end else begin
            slot = r_filled[SLOT_W-1:0];
        end
        fault_inc = (r_faults == '1) ? r_faults : r_faults + FAULT_W'(1);
    end

    // control
    always_comb begin
        n_state = r_state;
        in_xfer = 1'b0;
        commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_xfer = i_req.valid;
                if (i_req.valid) n_state = ST_MATCH;
            end
            ST_MATCH: begin
                commit = !r_out_valid || o_rsp.ready;
                if (commit) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        upd.clear_all = in_xfer && i_req.new_sequence;
        upd.hit_en    = commit && any_hit;
        upd.write_en  = commit && !any_hit;
        upd.sweep_en  = commit && !any_hit && full;
        upd.wrap      = !any_hi;
        upd.slot      = slot;
    end

    always_comb begin
        n_filled = r_filled;
        n_hand   = r_hand;
        n_faults = r_faults;
        if (upd.clear_all) begin
            n_filled = '0;
            n_hand   = '0;
            n_faults = '0;
        end else if (upd.write_en) begin
            n_faults = fault_inc;
            if (!full) begin
                n_filled = r_filled + CNT_W'(1);
            end else if (CNT_W'(victim) + CNT_W'(1) == limit) begin
                n_hand = '0;
            end else begin
                n_hand = victim + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_frames <= CFG_RESET;
            r_filled <= '0;
            r_hand   <= '0;
            r_faults <= '0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_hand   <= n_hand;
            r_faults <= n_faults;
            if (i_cfg_we) r_frames <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_page <= i_req.page_number;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_fault    <= !any_hit;
            r_out_slot     <= slot;
            r_out_ev_valid <= upd.sweep_en;
            r_out_ev_page  <= upd.sweep_en ? pages[victim] : '0;
            r_out_total    <= any_hit ? r_faults : fault_inc;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.fault         = r_out_fault;
    assign o_rsp.frame_slot    = r_out_slot;
    assign o_rsp.evicted_valid = r_out_ev_valid;
    assign o_rsp.evicted_page  = r_out_ev_page;
    assign o_rsp.fault_total   = r_out_total;

endmodule

/* design/cpr_checker.sv */
module cpr_checker import cpr_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input logic  i_fault,
    input logic  i_ev_valid,
    input t_page i_ev_page,
    input t_slot i_slot
);

    // one reference in flight: no second transfer right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken on back-to-back cycles");

    // an eviction only happens on a fault
    a_evict_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_ev_valid) |-> i_fault)
        else $error("eviction reported on a hit");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_ev_valid) |-> (i_ev_page == '0))
        else $error("evicted page nonzero without eviction");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_slot)
                                           && $stable(i_fault)))
        else $error("stalled result changed");

endmodule

bind clock_page_replacement_top cpr_checker u_cpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_fault     (o_rsp.fault),
    .i_ev_valid  (o_rsp.evicted_valid),
    .i_ev_page   (o_rsp.evicted_page),
    .i_slot      (o_rsp.frame_slot)
);

/* sim/tb_clock_page_replacement_top.sv */
module tb_clock_page_replacement_top;
    import cpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A run with no transfer on either channel for this long is hung.
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_CHUNKS = 10;
    localparam int CHUNK_ITEMS = 100;
    localparam int N_DIR       = 23;
    localparam int PRINT_CAP   = 50;

    // One lookup result, field for field as the response channel carries it.
    typedef struct packed {
        logic       fault;
        t_slot      slot;
        logic       ev_valid;
        t_page      ev_page;
        t_fault_cnt total;
    } t_resp;

    // One page reference; typed rows carry a hand-written result.
    typedef struct packed {
        t_page page;
        logic  fresh;
        logic  typed;
        t_resp want;
    } t_ref;

    // Directed table row: optional frame count write (when idle), then the reference.
    typedef struct packed {
        logic             set_cfg;
        logic [CFG_W-1:0] cfg;
        t_ref             item;
    } t_dir_row;

    // Rows 0..5 run under the reset frame count of 4; the typed results follow the
    // fill order and the first second-chance eviction. Rows 6..10 set every bit and
    // force a full sweep of the hand. Row 11 starts a new sequence. Rows 12..15 use
    // a frame count of zero, which acts as a single frame. Later rows change the
    // count mid-sequence: 31 (clamped to 16), 3, then 2 with the hand past the end
    // and a resident page outside the active slots, then 16 again.
    localparam t_dir_row DIR_TABLE [N_DIR] = '{
        '{1'b0, 5'd0,  '{16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1}}},
        '{1'b0, 5'd0,  '{16'hFFFF, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}}},
        '{1'b0, 5'd0,  '{16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd2}}},
        '{1'b0, 5'd0,  '{16'h0001, 1'b0, 1'b1, '{1'b1, 4'd2, 1'b0, 16'h0000, 32'd3}}},
        '{1'b0, 5'd0,  '{16'h0002, 1'b0, 1'b1, '{1'b1, 4'd3, 1'b0, 16'h0000, 32'd4}}},
        '{1'b0, 5'd0,  '{16'h0003, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b1, 16'hFFFF, 32'd5}}},
        '{1'b0, 5'd0,  '{16'h0000, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'h0003, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'h0001, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'h0002, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'h5A5A, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'hFFFF, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1}}},
        '{1'b1, 5'd0,  '{16'h1234, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1}}},
        '{1'b0, 5'd0,  '{16'h1234, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}}},
        '{1'b0, 5'd0,  '{16'h4321, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h1234, 32'd2}}},
        '{1'b0, 5'd0,  '{16'h8000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h4321, 32'd3}}},
        '{1'b1, 5'd31, '{16'h8000, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'h7FFF, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'hAAAA, 1'b0, 1'b0, '0}},
        '{1'b1, 5'd3,  '{16'h5555, 1'b0, 1'b0, '0}},
        '{1'b1, 5'd2,  '{16'h0F0F, 1'b0, 1'b0, '0}},
        '{1'b0, 5'd0,  '{16'hAAAA, 1'b0, 1'b0, '0}},
        '{1'b1, 5'd16, '{16'h0000, 1'b0, 1'b0, '0}}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    cpr_in_if  req_if ();
    cpr_out_if rsp_if ();

    clock_page_replacement_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Shadow copy of the replacement state, updated on each request transfer.
    logic [CFG_W-1:0]      shadow_frames;
    t_page                 shadow_pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] shadow_ref;
    t_cnt                  shadow_filled;
    t_slot                 shadow_hand;
    t_fault_cnt            shadow_faults;

    t_ref  page_ref_q[$];       // references not yet driven
    t_resp lookup_result_q[$];  // results owed by the block, oldest first
    t_ref  cur_ref;             // reference currently on the request channel
    t_resp predicted_rsp;
    t_resp got_want;

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatch_count;
    int result_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic empty_shadow();
        foreach (shadow_pages[i])
            shadow_pages[i] = '0;
        shadow_ref    = '0;
        shadow_filled = '0;
        shadow_hand   = '0;
        shadow_faults = '0;
    endtask

    // Second-chance lookup on the shadow state: hit sets the bit, a miss fills the
    // next free slot or sweeps the hand to the first clear bit and replaces there.
    task automatic clock_replace(input t_page pg, input logic fresh, output t_resp r);
        int  lim;
        int  act;
        int  h;
        int  slot;
        bit  hit;
        if (fresh)
            empty_shadow();
        if (shadow_frames == 0)
            lim = 1;
        else if (shadow_frames > MAX_FRAMES)
            lim = MAX_FRAMES;
        else
            lim = int'(shadow_frames);
        act  = (shadow_filled < lim) ? int'(shadow_filled) : lim;
        hit  = 1'b0;
        slot = 0;
        for (int i = 0; i < act; i++) begin
            if (!hit && shadow_pages[i] == pg) begin
                hit  = 1'b1;
                slot = i;
            end
        end
        r = '0;
        if (hit) begin
            shadow_ref[slot] = 1'b1;
        end else begin
            if (shadow_faults != '1)
                shadow_faults++;
            if (shadow_filled < lim) begin
                slot = int'(shadow_filled);
                shadow_pages[slot] = pg;
                shadow_ref[slot]   = 1'b0;
                shadow_filled++;
            end else begin
                h = (shadow_hand >= lim) ? 0 : int'(shadow_hand);
                // one lap at most clears every bit
                for (int i = 0; i <= lim && shadow_ref[h]; i++) begin
                    shadow_ref[h] = 1'b0;
                    h = (h + 1) % lim;
                end
                slot        = h;
                r.ev_valid  = 1'b1;
                r.ev_page   = shadow_pages[slot];
                shadow_pages[slot] = pg;
                shadow_ref[slot]   = 1'b0;
                shadow_hand = t_slot'((slot + 1) % lim);
            end
        end
        r.fault = ~hit;
        r.slot  = t_slot'(slot);
        r.total = shadow_faults;
    endtask

    // Idle point: nothing queued, nothing on the channel, nothing owed, plus a margin.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (page_ref_q.size() != 0 || req_if.valid || lookup_result_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // Frame count write; only called at an idle point.
    task automatic write_frames(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        shadow_frames = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Request side: on a transfer, run the shadow model and log what is owed;
    // then offer the next reference unless this cycle is an idle one.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            clock_replace(req_if.page_number, req_if.new_sequence, predicted_rsp);
            lookup_result_q.insert(lookup_result_q.size(),
                                   cur_ref.typed ? cur_ref.want : predicted_rsp);
        end
        if (!req_if.valid || req_if.ready) begin
            if (page_ref_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_ref = page_ref_q.pop_front();
                req_if.valid        <= 1'b1;
                req_if.page_number  <= cur_ref.page;
                req_if.new_sequence <= cur_ref.fresh;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response side backpressure.
    always @(posedge i_clk) begin
        rsp_if.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // Every response transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (lookup_result_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing owed", result_count));
            end else begin
                got_want = lookup_result_q.pop_front();
                if (rsp_if.fault !== got_want.fault)
                    flag_mismatch($sformatf("result %0d fault: got %0b want %0b",
                        result_count, rsp_if.fault, got_want.fault));
                if (rsp_if.frame_slot !== got_want.slot)
                    flag_mismatch($sformatf("result %0d frame_slot: got %0d want %0d",
                        result_count, rsp_if.frame_slot, got_want.slot));
                if (rsp_if.evicted_valid !== got_want.ev_valid)
                    flag_mismatch($sformatf("result %0d evicted_valid: got %0b want %0b",
                        result_count, rsp_if.evicted_valid, got_want.ev_valid));
                if (rsp_if.evicted_page !== got_want.ev_page)
                    flag_mismatch($sformatf("result %0d evicted_page: got %h want %h",
                        result_count, rsp_if.evicted_page, got_want.ev_page));
                if (rsp_if.fault_total !== got_want.total)
                    flag_mismatch($sformatf("result %0d fault_total: got %0d want %0d",
                        result_count, rsp_if.fault_total, got_want.total));
            end
            result_count++;
        end
    end

    // Hang detection: counts cycles with no transfer on either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : main_seq
        t_page            pool[$];
        t_ref             it;
        logic [CFG_W-1:0] cfg;
        int               wlim;
        int               ws;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_if.valid        = 1'b0;
        req_if.page_number  = '0;
        req_if.new_sequence = 1'b0;
        rsp_if.ready        = 1'b0;
        mismatch_count      = 0;
        result_count        = 0;
        tx_idle_pct         = 25;
        rx_idle_pct         = 81;
        shadow_frames       = CFG_RESET;
        empty_shadow();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; frame count writes wait for the block to go idle.
        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_TABLE[r].set_cfg) begin
                wait_drained();
                write_frames(DIR_TABLE[r].cfg);
            end
            page_ref_q.insert(page_ref_q.size(), DIR_TABLE[r].item);
        end

        // Random chunks: each picks a frame count and a working set up to four pages larger
        // than the frames, so hits, sweeps and evictions all keep happening. A few
        // references fall outside the set, and a few restart the sequence.
        for (int c = 0; c < RAND_CHUNKS; c++) begin
            wait_drained();
            if (c == 4) begin
                tx_idle_pct = 81;
                rx_idle_pct = 25;
            end else if (c == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (c)
                0:       cfg = 5'd1;
                1:       cfg = 5'd16;
                2:       cfg = 5'd0;
                3:       cfg = 5'd31;
                default: cfg = CFG_W'($urandom_range(31));
            endcase
            write_frames(cfg);
            wlim = (cfg == 0) ? 1 : ((cfg > MAX_FRAMES) ? MAX_FRAMES : int'(cfg));
            ws   = wlim + $urandom_range(4);
            pool.delete();
            repeat (ws) pool.insert(pool.size(), t_page'($urandom));
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                if ($urandom_range(99) < 8)
                    it.page = t_page'($urandom);
                else
                    it.page = pool[$urandom_range(ws - 1)];
                it.fresh = ($urandom_range(99) < 3);
                it.typed = 1'b0;
                it.want  = '0;
                page_ref_q.insert(page_ref_q.size(), it);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
design/cpr_pkg.sv
design/cpr_if.sv
design/cpr_cell.sv
design/clock_page_replacement_top.sv
design/cpr_checker.sv
sim/tb_clock_page_replacement_top.sv
